@@ sv/rb3d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rb3d_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned DivBits     = 12;
  localparam int unsigned RegionBits  = 24;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned NumAxes     = 3;
  localparam int unsigned QueueDepth  = 4;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SIZE_X = 3'd0,
    CFG_SIZE_Y = 3'd1,
    CFG_SIZE_Z = 3'd2,
    CFG_DIV_X  = 3'd3,
    CFG_DIV_Y  = 3'd4,
    CFG_DIV_Z  = 3'd5,
    CFG_MODE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_PLANE = 4'b0100,
    ST_TOTAL = 4'b1000
  } setup_state_e;

endpackage

`default_nettype wire

@@ sv/rb3d_setup.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rb3d_setup #(
  parameter int unsigned COORD_BITS = rb3d_pkg::CoordBits,
  parameter int unsigned DIV_BITS   = rb3d_pkg::DivBits,
  parameter int unsigned DATA_BITS  = (COORD_BITS > DIV_BITS) ? COORD_BITS : DIV_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [rb3d_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  wire logic [DATA_BITS-1:0]              cfg_data_i,
  output logic                                   ready_o,
  output logic                                   mode_o,
  output logic [COORD_BITS-1:0]                  size_o [rb3d_pkg::NumAxes],
  output logic [COORD_BITS-1:0]                  quot_o [rb3d_pkg::NumAxes],
  output logic [DIV_BITS-1:0]                    rem_o  [rb3d_pkg::NumAxes],
  output logic [COORD_BITS:0]                    step_o [rb3d_pkg::NumAxes],
  output logic [DIV_BITS-1:0]                    div_x_o,
  output logic [DIV_BITS-1:0]                    div_y_o,
  output logic [3*DIV_BITS-1:0]                  total_o
);
  import rb3d_pkg::*;

  localparam int unsigned CntBits = $clog2(COORD_BITS + 1);

  logic [COORD_BITS-1:0] size_q [NumAxes];
  logic [DIV_BITS-1:0]   div_q  [NumAxes];
  logic                  mode_q;
  logic [COORD_BITS-1:0] quot_q [NumAxes];
  logic [DIV_BITS-1:0]   rem_q  [NumAxes];
  setup_state_e          state_q;
  logic [1:0]            axis_q;
  logic [CntBits-1:0]    cnt_q;
  logic [COORD_BITS-1:0] work_q;
  logic [DIV_BITS-1:0]   part_q;
  logic [2*DIV_BITS-1:0] plane_q;
  logic [3*DIV_BITS-1:0] total_q;

  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     divisor_ext;
  logic                  ge;
  logic [DIV_BITS-1:0]   part_d;
  logic [COORD_BITS-1:0] work_d;

  // One quotient bit per cycle of the shared restoring divider.
  always_comb begin
    divisor_ext = {1'b0, div_q[axis_q]};
    trial       = {part_q, work_q[COORD_BITS-1]};
    ge          = (trial >= divisor_ext);
    part_d      = ge ? DIV_BITS'(trial - divisor_ext) : DIV_BITS'(trial);
    work_d      = {work_q[COORD_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= '{default: COORD_BITS'(1)};
      div_q   <= '{default: DIV_BITS'(1)};
      mode_q  <= 1'b0;
      quot_q  <= '{default: COORD_BITS'(1)};
      rem_q   <= '{default: '0};
      total_q <= (3*DIV_BITS)'(1);
      state_q <= ST_IDLE;
      axis_q  <= 2'd0;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SIZE_X: size_q[0] <= cfg_data_i[COORD_BITS-1:0];
        CFG_SIZE_Y: size_q[1] <= cfg_data_i[COORD_BITS-1:0];
        CFG_SIZE_Z: size_q[2] <= cfg_data_i[COORD_BITS-1:0];
        CFG_DIV_X:  div_q[0]  <= cfg_data_i[DIV_BITS-1:0];
        CFG_DIV_Y:  div_q[1]  <= cfg_data_i[DIV_BITS-1:0];
        CFG_DIV_Z:  div_q[2]  <= cfg_data_i[DIV_BITS-1:0];
        CFG_MODE:   mode_q    <= cfg_data_i[0];
        default: ;
      endcase
      // Any write restarts the derived-value pass from the first axis.
      state_q <= ST_DIV;
      axis_q  <= 2'd0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: ;
        ST_DIV: begin
          if (cnt_q == '0) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (cnt_q == CntBits'(COORD_BITS)) begin
            quot_q[axis_q] <= work_d;
            rem_q[axis_q]  <= part_d;
            cnt_q          <= '0;
            if (axis_q == 2'd2) begin
              state_q <= ST_PLANE;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_PLANE: state_q <= ST_TOTAL;
        ST_TOTAL: begin
          total_q <= (3*DIV_BITS)'(plane_q) * (3*DIV_BITS)'(div_q[2]);
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV) begin
      if (cnt_q == '0) begin
        work_q <= size_q[axis_q];
        part_q <= '0;
      end else begin
        work_q <= work_d;
        part_q <= part_d;
      end
    end
    if (state_q == ST_PLANE) begin
      plane_q <= (2*DIV_BITS)'(div_q[0]) * (2*DIV_BITS)'(div_q[1]);
    end
  end

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      step_o[a] = mode_q ? ({1'b0, quot_q[a]} + (COORD_BITS+1)'(rem_q[a] != '0))
                         : {1'b0, quot_q[a]};
    end
  end

  assign ready_o = (state_q == ST_IDLE);
  assign mode_o  = mode_q;
  assign size_o  = size_q;
  assign quot_o  = quot_q;
  assign rem_o   = rem_q;
  assign div_x_o = div_q[0];
  assign div_y_o = div_q[1];
  assign total_o = total_q;

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !ready_o)
    else $error("setup pass not started after a register write");

endmodule

`default_nettype wire

@@ sv/rb3d_divpipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rb3d_divpipe #(
  parameter int unsigned NUM_BITS  = rb3d_pkg::RegionBits,
  parameter int unsigned DIV_BITS  = rb3d_pkg::DivBits,
  parameter int unsigned SIDE_BITS = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [NUM_BITS-1:0]  num_i,
  input  wire logic [SIDE_BITS-1:0] side_i,
  input  wire logic [DIV_BITS-1:0]  divisor_i,
  output logic                      valid_o,
  output logic [NUM_BITS-1:0]       quot_o,
  output logic [DIV_BITS-1:0]       rem_o,
  output logic [SIDE_BITS-1:0]      side_o
);
  import rb3d_pkg::*;

  logic                 valid_q [NUM_BITS];
  logic [NUM_BITS-1:0]  work_q  [NUM_BITS];
  logic [DIV_BITS-1:0]  part_q  [NUM_BITS];
  logic [SIDE_BITS-1:0] side_q  [NUM_BITS];

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic                 v_in;
    logic [NUM_BITS-1:0]  w_in;
    logic [DIV_BITS-1:0]  p_in;
    logic [SIDE_BITS-1:0] s_in;
    logic [DIV_BITS:0]    trial;
    logic                 ge;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign w_in = num_i;
      assign p_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[s-1];
      assign w_in = work_q[s-1];
      assign p_in = part_q[s-1];
      assign s_in = side_q[s-1];
    end

    assign trial = {p_in, w_in[NUM_BITS-1]};
    assign ge    = (trial >= {1'b0, divisor_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    // Remaining dividend bits shift out at the top while quotient bits enter below.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[s] <= NUM_BITS'({w_in, ge});
        part_q[s] <= ge ? DIV_BITS'(trial - {1'b0, divisor_i}) : DIV_BITS'(trial);
        side_q[s] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[NUM_BITS-1];
  assign quot_o  = work_q[NUM_BITS-1];
  assign rem_o   = part_q[NUM_BITS-1];
  assign side_o  = side_q[NUM_BITS-1];

endmodule

`default_nettype wire

@@ sv/rb3d_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rb3d_front #(
  parameter int unsigned DIV_BITS    = rb3d_pkg::DivBits,
  parameter int unsigned REGION_BITS = rb3d_pkg::RegionBits
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire logic [REGION_BITS-1:0] region_id_i,
  input  wire logic [DIV_BITS-1:0]    div_x_i,
  input  wire logic [DIV_BITS-1:0]    div_y_i,
  input  wire logic [3*DIV_BITS-1:0]  total_i,
  output logic                        valid_o,
  output logic                        oor_o,
  output logic [DIV_BITS-1:0]         idx_o [rb3d_pkg::NumAxes]
);
  import rb3d_pkg::*;

  localparam int unsigned CmpBits =
    (REGION_BITS > 3*DIV_BITS) ? REGION_BITS : 3*DIV_BITS;

  logic                   oor_in;
  logic                   v1;
  logic [REGION_BITS-1:0] quot1;
  logic [DIV_BITS-1:0]    rem1;
  logic                   oor1;
  logic [REGION_BITS-1:0] quot2;
  logic [DIV_BITS-1:0]    rem2;
  logic [DIV_BITS:0]      side2;

  assign oor_in = (CmpBits'(region_id_i) >= CmpBits'(total_i));

  // The x index is the remainder by div_x; the quotient is split again by div_y.
  rb3d_divpipe #(
    .NUM_BITS (REGION_BITS),
    .DIV_BITS (DIV_BITS),
    .SIDE_BITS(1)
  ) u_div_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_i),
    .valid_i  (valid_i),
    .num_i    (region_id_i),
    .side_i   (oor_in),
    .divisor_i(div_x_i),
    .valid_o  (v1),
    .quot_o   (quot1),
    .rem_o    (rem1),
    .side_o   (oor1)
  );

  rb3d_divpipe #(
    .NUM_BITS (REGION_BITS),
    .DIV_BITS (DIV_BITS),
    .SIDE_BITS(DIV_BITS + 1)
  ) u_div_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_i),
    .valid_i  (v1),
    .num_i    (quot1),
    .side_i   ({oor1, rem1}),
    .divisor_i(div_y_i),
    .valid_o  (valid_o),
    .quot_o   (quot2),
    .rem_o    (rem2),
    .side_o   (side2)
  );

  assign oor_o    = side2[DIV_BITS];
  assign idx_o[0] = side2[DIV_BITS-1:0];
  assign idx_o[1] = rem2;
  assign idx_o[2] = DIV_BITS'(quot2);

endmodule

`default_nettype wire

@@ sv/rb3d_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rb3d_back #(
  parameter int unsigned COORD_BITS = rb3d_pkg::CoordBits,
  parameter int unsigned DIV_BITS   = rb3d_pkg::DivBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  output logic                       en_o,
  input  wire logic                  valid_i,
  input  wire logic                  oor_i,
  input  wire logic [DIV_BITS-1:0]   idx_i  [rb3d_pkg::NumAxes],
  input  wire logic                  mode_i,
  input  wire logic [COORD_BITS-1:0] size_i [rb3d_pkg::NumAxes],
  input  wire logic [COORD_BITS-1:0] quot_i [rb3d_pkg::NumAxes],
  input  wire logic [DIV_BITS-1:0]   rem_i  [rb3d_pkg::NumAxes],
  input  wire logic [COORD_BITS:0]   step_i [rb3d_pkg::NumAxes],
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [COORD_BITS:0]        head_o [rb3d_pkg::NumAxes],
  output logic [COORD_BITS-1:0]      tail_o [rb3d_pkg::NumAxes],
  output logic                       oor_o
);
  import rb3d_pkg::*;

  localparam int unsigned ProdBits = COORD_BITS + 1 + DIV_BITS;
  localparam int unsigned SumBits  = ProdBits + 1;
  localparam int unsigned HeadBits = COORD_BITS + 1;
  localparam int unsigned EntBits  = NumAxes * (HeadBits + COORD_BITS) + 1;
  localparam int unsigned PtrBits  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits  = $clog2(QueueDepth + 1);

  logic                  v1_q;
  logic                  oor1_q;
  logic [DIV_BITS-1:0]   idx1_q  [NumAxes];
  logic [ProdBits-1:0]   prod1_q [NumAxes];

  logic                  v2_q;
  logic                  oor2_q;
  logic [HeadBits-1:0]   head2_q [NumAxes];
  logic [COORD_BITS-1:0] tail2_q [NumAxes];

  logic [HeadBits-1:0]   head_d [NumAxes];
  logic [COORD_BITS-1:0] tail_d [NumAxes];

  logic [EntBits-1:0]    mem_q [QueueDepth];
  logic [PtrBits-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]    count_q;
  logic                  push, pop;
  logic [EntBits-1:0]    wr_ent, rd_ent;

  // The whole back end holds while the queue is full; the queue parts it from the sink.
  assign en_o = (count_q != CntBits'(QueueDepth));

  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    logic [DIV_BITS-1:0] lo;
    logic [DIV_BITS:0]   idx_p1;
    logic [DIV_BITS:0]   hi;
    logic [SumBits-1:0]  bal_head, bal_tail, blk_head, blk_end, blk_tail;

    always_comb begin
      lo       = (rem_i[a] < idx1_q[a]) ? rem_i[a] : idx1_q[a];
      idx_p1   = {1'b0, idx1_q[a]} + (DIV_BITS+1)'(1);
      hi       = ({1'b0, rem_i[a]} < idx_p1) ? {1'b0, rem_i[a]} : idx_p1;
      bal_head = SumBits'(prod1_q[a]) + SumBits'(lo) + SumBits'(1);
      bal_tail = SumBits'(prod1_q[a]) + SumBits'(quot_i[a]) + SumBits'(hi);
      blk_head = SumBits'(prod1_q[a]) + SumBits'(1);
      blk_end  = SumBits'(prod1_q[a]) + SumBits'(step_i[a]);
      blk_tail = (blk_end < SumBits'(size_i[a])) ? blk_end : SumBits'(size_i[a]);
      if (oor1_q) begin
        head_d[a] = '0;
        tail_d[a] = '0;
      end else if (mode_i) begin
        head_d[a] = blk_head[HeadBits-1:0];
        tail_d[a] = blk_tail[COORD_BITS-1:0];
      end else begin
        head_d[a] = bal_head[HeadBits-1:0];
        tail_d[a] = bal_tail[COORD_BITS-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_o) begin
        idx1_q[a]  <= idx_i[a];
        prod1_q[a] <= ProdBits'(step_i[a]) * ProdBits'(idx_i[a]);
        head2_q[a] <= head_d[a];
        tail2_q[a] <= tail_d[a];
      end
    end

    assign wr_ent[a*(HeadBits+COORD_BITS) +: HeadBits+COORD_BITS] = {head2_q[a], tail2_q[a]};
    assign head_o[a] = rd_ent[a*(HeadBits+COORD_BITS)+COORD_BITS +: HeadBits];
    assign tail_o[a] = rd_ent[a*(HeadBits+COORD_BITS) +: COORD_BITS];
  end

  assign wr_ent[EntBits-1] = oor2_q;
  assign rd_ent            = mem_q[rd_ptr_q];
  assign oor_o             = rd_ent[EntBits-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_o) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      oor1_q <= oor_i;
      oor2_q <= oor1_q;
    end
  end

  assign push        = en_o && v2_q;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(QueueDepth))
    else $error("result queue over its depth");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && oor2_q) |-> (head2_q[0] == '0 && tail2_q[0] == '0 &&
                          head2_q[1] == '0 && tail2_q[1] == '0 &&
                          head2_q[2] == '0 && tail2_q[2] == '0))
    else $error("out-of-range region carries non-zero bounds");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_o |=> ($stable(v2_q) && $stable(v1_q)))
    else $error("back end moved while the queue was full");

endmodule

`default_nettype wire

@@ sv/region_bounds_3d_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we_i                  cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_ready_o   region_id_i
// out       out        out_valid_o / out_ready_i head_*_o, tail_*_o, out_of_range_o
//
// One region number is taken per cycle while in_ready_o is high; a result passes through
// the two bit-per-stage index dividers, the two back stages and the result queue.
// Out of reset the derived values already match the reset registers, so input is taken
// at once. After every register write, a pass derives the per-axis quotients one axis
// at a time, then the region count; in_ready_o is low meanwhile.
// A four-entry result queue decouples the sink; when it is full the pipeline holds.

module region_bounds_3d_unit #(
  parameter int unsigned COORD_BITS  = rb3d_pkg::CoordBits,
  parameter int unsigned DIV_BITS    = rb3d_pkg::DivBits,
  parameter int unsigned REGION_BITS = rb3d_pkg::RegionBits,
  parameter int unsigned DATA_BITS   = (COORD_BITS > DIV_BITS) ? COORD_BITS : DIV_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rb3d_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [DATA_BITS-1:0]            cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [REGION_BITS-1:0]          region_id_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [COORD_BITS:0]                  head_x_o,
  output logic [COORD_BITS:0]                  head_y_o,
  output logic [COORD_BITS:0]                  head_z_o,
  output logic [COORD_BITS-1:0]                tail_x_o,
  output logic [COORD_BITS-1:0]                tail_y_o,
  output logic [COORD_BITS-1:0]                tail_z_o,
  output logic                                 out_of_range_o
);
  import rb3d_pkg::*;

  logic                  setup_ready;
  logic                  mode;
  logic [COORD_BITS-1:0] size [NumAxes];
  logic [COORD_BITS-1:0] quot [NumAxes];
  logic [DIV_BITS-1:0]   rem  [NumAxes];
  logic [COORD_BITS:0]   step [NumAxes];
  logic [DIV_BITS-1:0]   div_x, div_y;
  logic [3*DIV_BITS-1:0] total;
  logic                  en;
  logic                  f_valid, f_oor;
  logic [DIV_BITS-1:0]   f_idx [NumAxes];
  logic [COORD_BITS:0]   head [NumAxes];
  logic [COORD_BITS-1:0] tail [NumAxes];

  assign in_ready_o = en && setup_ready;

  rb3d_setup #(
    .COORD_BITS(COORD_BITS),
    .DIV_BITS  (DIV_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .ready_o    (setup_ready),
    .mode_o     (mode),
    .size_o     (size),
    .quot_o     (quot),
    .rem_o      (rem),
    .step_o     (step),
    .div_x_o    (div_x),
    .div_y_o    (div_y),
    .total_o    (total)
  );

  rb3d_front #(
    .DIV_BITS   (DIV_BITS),
    .REGION_BITS(REGION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i && in_ready_o),
    .region_id_i(region_id_i),
    .div_x_i    (div_x),
    .div_y_i    (div_y),
    .total_i    (total),
    .valid_o    (f_valid),
    .oor_o      (f_oor),
    .idx_o      (f_idx)
  );

  rb3d_back #(
    .COORD_BITS(COORD_BITS),
    .DIV_BITS  (DIV_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_o       (en),
    .valid_i    (f_valid),
    .oor_i      (f_oor),
    .idx_i      (f_idx),
    .mode_i     (mode),
    .size_i     (size),
    .quot_i     (quot),
    .rem_i      (rem),
    .step_i     (step),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head),
    .tail_o     (tail),
    .oor_o      (out_of_range_o)
  );

  assign head_x_o = head[0];
  assign head_y_o = head[1];
  assign head_z_o = head[2];
  assign tail_x_o = tail[0];
  assign tail_y_o = tail[1];
  assign tail_z_o = tail[2];

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import rb3d_pkg::*;

  localparam logic [CfgIdxBits-1:0] CfgUnused = 3'd7;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 2 * RegionBits + 10;

  typedef struct packed {
    logic [CoordBits:0]   head_x;
    logic [CoordBits:0]   head_y;
    logic [CoordBits:0]   head_z;
    logic [CoordBits-1:0] tail_x;
    logic [CoordBits-1:0] tail_y;
    logic [CoordBits-1:0] tail_z;
    logic                 out_of_range;
  } bounds_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [CoordBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [RegionBits-1:0] region_id_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CoordBits:0] head_x_o, head_y_o, head_z_o;
  logic [CoordBits-1:0] tail_x_o, tail_y_o, tail_z_o;
  logic out_of_range_o;

  region_bounds_3d_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .region_id_i,
    .out_valid_o, .out_ready_i,
    .head_x_o, .head_y_o, .head_z_o, .tail_x_o, .tail_y_o, .tail_z_o,
    .out_of_range_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the grid and division registers.
  longint unsigned grid_size[3];
  longint unsigned grid_div[3];
  bit              block_mode;

  bounds_t pending_bounds[$];
  int      error_count = 0;
  int      send_idle_pct = 0;
  int      sink_idle_pct = 0;
  int      sink_hold_left = 0;
  int      quiet_cycles = 0;

  task automatic axis_span(input longint unsigned sz, input longint unsigned dv,
                           input longint unsigned idx, output longint unsigned head,
                           output longint unsigned tail);
    longint unsigned q, r, blk, lo, hi;
    q = sz / dv;
    r = sz % dv;
    if (block_mode) begin
      blk = q + ((r != 0) ? 1 : 0);
      head = blk * idx + 1;
      tail = head + blk - 1;
      if (tail > sz) tail = sz;
    end else begin
      lo = (r < idx) ? r : idx;
      hi = (r < idx + 1) ? r : idx + 1;
      head = q * idx + lo + 1;
      tail = q * (idx + 1) + hi;
    end
  endtask

  task automatic region_bounds(input logic [RegionBits-1:0] rid, output bounds_t b);
    longint unsigned plane, total, h[3], t[3], idx[3];
    plane = grid_div[0] * grid_div[1];
    total = plane * grid_div[2];
    b = '0;
    if (rid >= total) begin
      b.out_of_range = 1'b1;
    end else begin
      idx[0] = rid % grid_div[0];
      idx[1] = (rid / grid_div[0]) % grid_div[1];
      idx[2] = rid / plane;
      for (int a = 0; a < 3; a++) axis_span(grid_size[a], grid_div[a], idx[a], h[a], t[a]);
      b.head_x = h[0][CoordBits:0];
      b.head_y = h[1][CoordBits:0];
      b.head_z = h[2][CoordBits:0];
      b.tail_x = t[0][CoordBits-1:0];
      b.tail_y = t[1][CoordBits-1:0];
      b.tail_z = t[2][CoordBits-1:0];
    end
  endtask

  // Result sink with random stalls and an optional long hold-off.
  always @(negedge clk_i) begin
    if (sink_hold_left > 0) begin
      sink_hold_left <= sink_hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    bounds_t got, want;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (out_valid_o && out_ready_i) begin
      got = '{head_x_o, head_y_o, head_z_o, tail_x_o, tail_y_o, tail_z_o, out_of_range_o};
      if (pending_bounds.size() == 0) begin
        $display("%0t: unexpected result transfer %p", $realtime, got);
        error_count++;
      end else begin
        want = pending_bounds.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime, want, got);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_region(input logic [RegionBits-1:0] rid);
    bounds_t b;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    region_id_i = rid;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    region_bounds(rid, b);
    pending_bounds.push_back(b);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CoordBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_SIZE_X: grid_size[0] = 64'(val);
      CFG_SIZE_Y: grid_size[1] = 64'(val);
      CFG_SIZE_Z: grid_size[2] = 64'(val);
      CFG_DIV_X:  grid_div[0] = 64'(val[DivBits-1:0]);
      CFG_DIV_Y:  grid_div[1] = 64'(val[DivBits-1:0]);
      CFG_DIV_Z:  grid_div[2] = 64'(val[DivBits-1:0]);
      CFG_MODE:   block_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input int sx, input int sy, input int sz, input int dx,
                          input int dy, input int dz, input bit mode);
    wait_drained();
    write_reg(CFG_SIZE_X, CoordBits'(sx));
    write_reg(CFG_SIZE_Y, CoordBits'(sy));
    write_reg(CFG_SIZE_Z, CoordBits'(sz));
    write_reg(CFG_DIV_X, CoordBits'(dx));
    write_reg(CFG_DIV_Y, CoordBits'(dy));
    write_reg(CFG_DIV_Z, CoordBits'(dz));
    write_reg(CFG_MODE, CoordBits'(mode));
  endtask

  task automatic test_reset_values();
    send_region(0);
    send_region(1);
    send_region('1);
  endtask

  task automatic test_largest_grid();
    for (int m = 0; m < 2; m++) begin
      set_grid(65535, 65535, 65535, 4095, 4095, 4095, m);
      send_region(0);
      send_region(4094);
      send_region(4095 * 4095 - 1);
      send_region('1);
      send_region(24'h555555);
      send_region(24'hAAAAAA);
    end
  endtask

  task automatic test_special_cases();
    // Division count with upper data bits set masks to zero: all out of range.
    set_grid(100, 100, 100, 16'hF000, 3, 3, 0);
    send_region(0);
    send_region(5);
    // Zero grid size gives an empty range on that axis.
    set_grid(0, 7, 1, 2, 3, 1, 0);
    send_region(0);
    send_region(5);
    send_region(6);
    // Block mode with a trailing region left empty.
    set_grid(5, 10, 3, 4, 3, 3, 1);
    send_region(3);
    send_region(35);
    wait_drained();
    write_reg(CfgUnused, 16'hFFFF);
    send_region(17);
  endtask

  task automatic random_grid();
    int s[3], d[3];
    for (int a = 0; a < 3; a++) begin
      d[a] = ($urandom_range(3) == 0) ? $urandom_range(4095, 1) : $urandom_range(16, 1);
      case ($urandom_range(3))
        0: s[a] = $urandom_range(65535, 1);
        1: s[a] = $urandom_range(d[a] + 3, 1);
        default: s[a] = $urandom_range(200, 1);
      endcase
    end
    set_grid(s[0], s[1], s[2], d[0], d[1], d[2], $urandom_range(1));
  endtask

  task automatic random_regions(input int count);
    longint unsigned total;
    logic [RegionBits-1:0] rid;
    total = grid_div[0] * grid_div[1] * grid_div[2];
    repeat (count) begin
      if ($urandom_range(9) == 0 || total == 0) begin
        rid = RegionBits'($urandom);
      end else begin
        if (total > (1 << RegionBits)) total = 1 << RegionBits;
        rid = RegionBits'($urandom_range(32'(total - 1)));
      end
      send_region(rid);
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle_pct = 17; sink_idle_pct = 46;
      end else if (p < 6) begin
        send_idle_pct = 46; sink_idle_pct = 17;
      end else begin
        send_idle_pct = 0; sink_idle_pct = 0;
      end
      random_grid();
      random_regions(150);
    end
  endtask

  task automatic test_sink_hold_off();
    send_idle_pct = 0;
    sink_idle_pct = 0;
    random_grid();
    sink_hold_left = 400;
    random_regions(60);
  endtask

  initial begin
    grid_size = '{1, 1, 1};
    grid_div = '{1, 1, 1};
    block_mode = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_values();
    test_largest_grid();
    test_special_cases();
    test_random_traffic();
    test_sink_hold_off();
    wait_drained();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
